// ----- rtl/prrl_pkg.sv -----
// Package for the per-id replay rate limiter.
// Holds field widths, op codes, controller states and the command/status structs.
// No dependencies.
package prrl_pkg;

  localparam int SOUND_ID_W = 16;
  localparam int INTERVAL_W = 31;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic tick;
    logic start;
    logic step;
    logic renew;
    logic deny;
    logic append;
    logic untrack;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic waited;
    logic last;
    logic seen;
    logic full;
    logic fill_zero;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/prrl_if.sv -----
// Channel interfaces for the per-id replay rate limiter.
// Query/tick input channel and result channel with valid/ready handshake.
// Depends on prrl_pkg.
interface prrl_in_if;
  import prrl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [SOUND_ID_W-1:0] sound_id;
  logic [INTERVAL_W-1:0] min_interval;
  modport source (output valid, op, sound_id, min_interval, input ready);
  modport sink   (input valid, op, sound_id, min_interval, output ready);
endinterface

interface prrl_out_if;
  logic valid;
  logic ready;
  logic allowed;
  logic untracked;
  modport source (output valid, allowed, untracked, input ready);
  modport sink   (input valid, allowed, untracked, output ready);
endinterface

// ----- rtl/per_id_replay_rate_limiter.sv -----
// Per-id replay rate limiter, top level.
// Items enter on in_ch: op = tick advances the tick counter and gives no result;
// op = query carries sound_id and min_interval and gives one result on out_ch
// (allowed, untracked). Up to ENTRIES ids are kept in a table walked in the
// order they were added; the first matching id that has waited at least
// min_interval ticks is renewed and allowed, a matching id that is too soon is
// denied, an unknown id is appended and allowed, or flagged untracked if full.
// A tick is handled in the idle state, which stays ready. A query walks the fill
// stored ids (fill up to ENTRIES), ending early on a renewal; the walk reads one
// entry per cycle from table memories with one read and one write port, and no
// new item is taken until the query's result is loaded. With the output register
// free, a result becomes valid in the cycle the block turns ready again.
// Reset empties the table, clears the tick counter and drops any pending result.
// A result waits in the output register while out_ch.ready is low; the block
// still takes the next item, and a query finishes its walk and holds its result
// until the output register is free.
// Depends on prrl_pkg, prrl_if, prrl_ctrl and prrl_dpath.
module per_id_replay_rate_limiter #(
  parameter int ENTRIES   = 32,
  parameter int KEY_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  prrl_in_if.sink    in_ch,
  prrl_out_if.source out_ch
);
  import prrl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prrl_dpath #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sound_id     (in_ch.sound_id),
    .in_min_interval (in_ch.min_interval),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_allowed     (out_ch.allowed),
    .out_untracked   (out_ch.untracked)
  );

endmodule

// ----- rtl/prrl_ctrl.sv -----
// Controller state machine of the per-id replay rate limiter.
// Sequences table scan, stamp renewal, append and result hand-off.
// Depends on prrl_pkg.
module prrl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_ready,
  input  prrl_pkg::sts_t sts,
  output prrl_pkg::cmd_t cmd
);
  import prrl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_QUERY) begin
          state_nxt = sts.fill_zero ? ST_END : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit && sts.waited) begin
          state_nxt = ST_DONE;
        end else if (sts.last) begin
          state_nxt = ST_END;
        end
      end
      ST_END: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.tick  = in_valid && in_op == OP_TICK;
        cmd.start = in_valid && in_op == OP_QUERY;
      end
      ST_SCAN: begin
        if (sts.hit && sts.waited) begin
          cmd.renew = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_END: begin
        if (sts.seen) begin
          cmd.deny = 1'b1;
        end else if (!sts.full) begin
          cmd.append = 1'b1;
        end else begin
          cmd.untrack = 1'b1;
        end
      end
      ST_DONE: cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/prrl_dpath.sv -----
// Datapath of the per-id replay rate limiter.
// Tick counter, key/stamp table memories, scan pointer, compare and result register.
// Depends on prrl_pkg.
module prrl_dpath #(
  parameter int ENTRIES   = 32,
  parameter int KEY_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  prrl_pkg::cmd_t                  cmd,
  output prrl_pkg::sts_t                  sts,
  input  logic [prrl_pkg::SOUND_ID_W-1:0] in_sound_id,
  input  logic [prrl_pkg::INTERVAL_W-1:0] in_min_interval,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_allowed,
  output logic                            out_untracked
);
  import prrl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (TIME_BITS > INTERVAL_W) ? TIME_BITS : INTERVAL_W;

  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [TIME_BITS-1:0]  stamp_mem [ENTRIES];

  logic [TIME_BITS-1:0]  now_r;
  logic [CNT_W-1:0]      fill_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  seen_r;
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [TIME_BITS-1:0]  rd_stamp_r;
  logic                  res_allowed_r;
  logic                  res_untracked_r;
  logic                  out_valid_r;
  logic                  out_allowed_r;
  logic                  out_untracked_r;

  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic [TIME_BITS-1:0]  elapsed;

  assign rd_addr = cmd.start ? '0 : idx_r + IDX_W'(1);
  assign wr_addr = cmd.append ? fill_r[IDX_W-1:0] : idx_r;
  assign elapsed = now_r - rd_stamp_r;

  assign sts.hit       = rd_key_r == key_r;
  assign sts.waited    = CMP_W'(elapsed) >= CMP_W'(interval_r);
  assign sts.last      = (CNT_W'(idx_r) + CNT_W'(1)) == fill_r;
  assign sts.seen      = seen_r;
  assign sts.full      = fill_r == CNT_W'(ENTRIES);
  assign sts.fill_zero = fill_r == '0;
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    rd_key_r   <= key_mem[rd_addr];
    rd_stamp_r <= stamp_mem[rd_addr];
    if (cmd.append) begin
      key_mem[wr_addr] <= key_r;
    end
    if (cmd.append || cmd.renew) begin
      stamp_mem[wr_addr] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick) begin
        now_r <= now_r + TIME_BITS'(1);
      end
      if (cmd.append) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r      <= KEY_BITS'(in_sound_id);
      interval_r <= in_min_interval;
      idx_r      <= '0;
      seen_r     <= 1'b0;
    end else if (cmd.step) begin
      idx_r  <= idx_r + IDX_W'(1);
      seen_r <= seen_r | sts.hit;
    end
    if (cmd.renew || cmd.append) begin
      res_allowed_r   <= 1'b1;
      res_untracked_r <= 1'b0;
    end else if (cmd.deny) begin
      res_allowed_r   <= 1'b0;
      res_untracked_r <= 1'b0;
    end else if (cmd.untrack) begin
      res_allowed_r   <= 1'b1;
      res_untracked_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_allowed_r   <= res_allowed_r;
      out_untracked_r <= res_untracked_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_allowed   = out_allowed_r;
  assign out_untracked = out_untracked_r;

endmodule

// ----- rtl/prrl_checker.sv -----
// Port-level checker for the per-id replay rate limiter, bound to the top level.
// Watches the input and result channels over time.
// Depends on prrl_pkg and per_id_replay_rate_limiter.
module prrl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready,
  input logic out_allowed,
  input logic out_untracked
);
  import prrl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_TICK && !out_valid |=> !out_valid)
    else $error("tick produced a result");

  a_untracked_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_allowed || !out_untracked)
    else $error("untracked result not allowed");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("query did not block input");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind per_id_replay_rate_limiter prrl_checker u_prrl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_op         (in_ch.op),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_allowed   (out_ch.allowed),
  .out_untracked (out_ch.untracked)
);
